@@ rtl/tlpw_pkg.sv @@
// ============================================================================
// Two-level page walk memory package
// Shared types, codes and sizes for the paged byte memory block.
// ============================================================================
package tlpw_pkg;

    localparam int MEM_ADDR_BITS = 16;
    localparam logic [32:0] MEM_BYTES = 33'd1 << MEM_ADDR_BITS;

    localparam logic [1:0] FN_PHYS_WR = 2'd0;
    localparam logic [1:0] FN_PHYS_RD = 2'd1;
    localparam logic [1:0] FN_VIRT_RD = 2'd2;
    localparam logic [1:0] FN_VIRT_WR = 2'd3;

    localparam logic [2:0] STAT_OK           = 3'd0;
    localparam logic [2:0] STAT_DIR_ABSENT   = 3'd1;
    localparam logic [2:0] STAT_TABLE_ABSENT = 3'd2;
    localparam logic [2:0] STAT_BAD_LEN      = 3'd3;
    localparam logic [2:0] STAT_RANGE        = 3'd4;

    localparam logic [1:0] REG_PAGING_ON     = 2'd0;
    localparam logic [1:0] REG_PROTECT_ON    = 2'd1;
    localparam logic [1:0] REG_DIR_BASE      = 2'd2;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] access_address;
        logic [2:0]  access_length;
        logic [31:0] write_data;
    } tlpw_in_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic [31:0] phys_address;
        logic [2:0]  status;
    } tlpw_out_t;

    typedef struct packed {
        logic        paging_on;
        logic        protect_on;
        logic [19:0] dir_base_frame;
    } tlpw_cfg_t;

endpackage

@@ rtl/tlpw_mem.sv @@
// ============================================================================
// Byte memory
// Single-port byte-wide memory with a registered read port.
// ============================================================================
module tlpw_mem
    import tlpw_pkg::*;
(
    input  logic                     aclk,
    input  logic                     we,
    input  logic [MEM_ADDR_BITS-1:0] addr,
    input  logic [7:0]               wdata,
    output logic [7:0]               rdata
);

    logic [7:0] mem [MEM_BYTES];
    logic [7:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/tlpw_agu.sv @@
// ============================================================================
// Address unit
// Shared adder that forms byte addresses and checks spans against memory size.
// ============================================================================
module tlpw_agu
    import tlpw_pkg::*;
(
    input  logic [31:0]              base,
    input  logic [2:0]               offset,
    output logic [MEM_ADDR_BITS-1:0] byte_addr,
    output logic                     in_range
);

    logic [32:0] sum;

    assign sum       = {1'b0, base} + {30'd0, offset};
    assign byte_addr = sum[MEM_ADDR_BITS-1:0];
    assign in_range  = (sum <= MEM_BYTES);

endmodule

@@ rtl/tlpw_walk.sv @@
// ============================================================================
// Page walk sequencer
// Runs the directory and table reads and the data access, one byte a cycle.
// ============================================================================
module tlpw_walk
    import tlpw_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  tlpw_cfg_t cfg,
    input  logic      s_valid,
    output logic      s_ready,
    input  tlpw_in_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output tlpw_out_t m_data
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_DECODE = 7'b0000010,
        S_CHECK  = 7'b0000100,
        S_WRITE  = 7'b0001000,
        S_READ   = 7'b0010000,
        S_WAIT   = 7'b0100000,
        S_DONE   = 7'b1000000
    } walk_state_t;

    typedef enum logic [2:0] {
        PH_DIR  = 3'b001,
        PH_TAB  = 3'b010,
        PH_DATA = 3'b100
    } walk_phase_t;

    walk_state_t state_reg, state_next;
    walk_phase_t phase_reg, phase_next;
    tlpw_in_t    item_reg, item_next;
    logic [31:0] cur_addr_reg, cur_addr_next;
    logic [2:0]  xfer_len_reg, xfer_len_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic        rd_pend_reg, rd_pend_next;
    logic [1:0]  rd_idx_reg, rd_idx_next;
    logic [31:0] acc_reg, acc_next, acc_merged;
    logic [31:0] res_rdata_reg, res_rdata_next;
    logic [31:0] res_paddr_reg, res_paddr_next;
    logic [2:0]  res_status_reg, res_status_next;
    logic        m_valid_reg;
    tlpw_out_t   m_data_reg;

    logic [2:0]               agu_offset;
    logic [MEM_ADDR_BITS-1:0] agu_addr;
    logic                     agu_in_range;
    logic                     mem_we;
    logic [7:0]               mem_rdata;
    logic                     is_virtual, is_write, last_byte, out_load, bad_len;

    tlpw_agu u_agu (
        .base      (cur_addr_reg),
        .offset    (agu_offset),
        .byte_addr (agu_addr),
        .in_range  (agu_in_range)
    );

    tlpw_mem u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .addr  (agu_addr),
        .wdata (item_reg.write_data[8*cnt_reg +: 8]),
        .rdata (mem_rdata)
    );

    assign agu_offset = (state_reg == S_CHECK) ? xfer_len_reg : {1'b0, cnt_reg};
    assign mem_we     = (state_reg == S_WRITE);
    assign is_virtual = (item_reg.func == FN_VIRT_RD) || (item_reg.func == FN_VIRT_WR);
    assign is_write   = (item_reg.func == FN_PHYS_WR) || (item_reg.func == FN_VIRT_WR);
    assign last_byte  = ({1'b0, cnt_reg} == (xfer_len_reg - 3'd1));
    assign out_load   = (state_reg == S_DONE) && (!m_valid_reg || m_ready);
    assign bad_len    = (item_reg.access_length == 3'd0) || (item_reg.access_length > 3'd4)
                        || (is_virtual && cfg.paging_on && item_reg.access_length == 3'd3);

    always_comb begin
        acc_merged = acc_reg;
        if (rd_pend_reg) begin
            acc_merged[8*rd_idx_reg +: 8] = mem_rdata;
        end
    end

    always_comb begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        item_next       = item_reg;
        cur_addr_next   = cur_addr_reg;
        xfer_len_next   = xfer_len_reg;
        cnt_next        = cnt_reg;
        rd_pend_next    = 1'b0;
        rd_idx_next     = rd_idx_reg;
        acc_next        = acc_merged;
        res_rdata_next  = res_rdata_reg;
        res_paddr_next  = res_paddr_reg;
        res_status_next = res_status_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    item_next  = s_data;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                res_rdata_next = 32'd0;
                if (bad_len) begin
                    res_status_next = STAT_BAD_LEN;
                    res_paddr_next  = 32'd0;
                    state_next      = S_DONE;
                end else if (is_virtual && cfg.paging_on && cfg.protect_on) begin
                    cur_addr_next = {cfg.dir_base_frame, item_reg.access_address[31:22], 2'b00};
                    xfer_len_next = 3'd4;
                    phase_next    = PH_DIR;
                    state_next    = S_CHECK;
                end else begin
                    cur_addr_next = item_reg.access_address;
                    xfer_len_next = item_reg.access_length;
                    phase_next    = PH_DATA;
                    state_next    = S_CHECK;
                end
            end
            S_CHECK: begin
                cnt_next = 2'd0;
                acc_next = 32'd0;
                if (!agu_in_range) begin
                    res_status_next = STAT_RANGE;
                    res_paddr_next  = cur_addr_reg;
                    state_next      = S_DONE;
                end else if (phase_reg == PH_DATA && is_write) begin
                    state_next = S_WRITE;
                end else begin
                    state_next = S_READ;
                end
            end
            S_WRITE: begin
                cnt_next = cnt_reg + 2'd1;
                if (last_byte) begin
                    res_status_next = STAT_OK;
                    res_paddr_next  = cur_addr_reg;
                    state_next      = S_DONE;
                end
            end
            S_READ: begin
                rd_pend_next = 1'b1;
                rd_idx_next  = cnt_reg;
                cnt_next     = cnt_reg + 2'd1;
                if (last_byte) begin
                    state_next = S_WAIT;
                end
            end
            S_WAIT: begin
                case (phase_reg)
                    PH_DIR: begin
                        if (!acc_merged[0]) begin
                            res_status_next = STAT_DIR_ABSENT;
                            res_paddr_next  = 32'd0;
                            state_next      = S_DONE;
                        end else begin
                            cur_addr_next = {acc_merged[31:12],
                                             item_reg.access_address[21:12], 2'b00};
                            phase_next    = PH_TAB;
                            state_next    = S_CHECK;
                        end
                    end
                    PH_TAB: begin
                        if (!acc_merged[0]) begin
                            res_status_next = STAT_TABLE_ABSENT;
                            res_paddr_next  = 32'd0;
                            state_next      = S_DONE;
                        end else begin
                            cur_addr_next = {acc_merged[31:12], item_reg.access_address[11:0]};
                            xfer_len_next = item_reg.access_length;
                            phase_next    = PH_DATA;
                            state_next    = S_CHECK;
                        end
                    end
                    default: begin
                        res_rdata_next  = acc_merged;
                        res_status_next = STAT_OK;
                        res_paddr_next  = cur_addr_reg;
                        state_next      = S_DONE;
                    end
                endcase
            end
            S_DONE: begin
                if (out_load) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            rd_pend_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            rd_pend_reg <= rd_pend_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        phase_reg      <= phase_next;
        item_reg       <= item_next;
        cur_addr_reg   <= cur_addr_next;
        xfer_len_reg   <= xfer_len_next;
        cnt_reg        <= cnt_next;
        rd_idx_reg     <= rd_idx_next;
        acc_reg        <= acc_next;
        res_rdata_reg  <= res_rdata_next;
        res_paddr_reg  <= res_paddr_next;
        res_status_reg <= res_status_next;
        if (out_load) begin
            m_data_reg.read_data    <= res_rdata_reg;
            m_data_reg.phys_address <= res_paddr_reg;
            m_data_reg.status       <= res_status_reg;
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef NO_ASSERTIONS
    a_write_only_data: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (phase_reg == PH_DATA) && is_write)
        else $error("Memory written outside the data phase of a write.");

    a_fault_no_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.status != STAT_OK) |-> (m_data_reg.read_data == 32'd0))
        else $error("Faulted transaction returned nonzero read data.");

    a_absent_zero_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_data_reg.status == STAT_DIR_ABSENT
                         || m_data_reg.status == STAT_TABLE_ABSENT))
        |-> (m_data_reg.phys_address == 32'd0))
        else $error("Absent entry reported with a nonzero physical address.");

    a_no_read_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !rd_pend_reg)
        else $error("Memory read still in flight while idle.");
`endif

endmodule

@@ rtl/two_level_page_walk_memory_top.sv @@
// ============================================================================
// Two-level page walk memory
// Little-endian byte memory with x86-style two-level address translation.
// ============================================================================
// One transaction is taken at a time, and all memory traffic goes through a
// single byte-wide port, one byte per cycle. A translated access first reads
// a four-byte directory entry, then a four-byte table entry, before the data
// access. Faults found before the data access finish sooner. The result sits
// in an output register, so a new transaction may be accepted while it waits.
module two_level_page_walk_memory_top
    import tlpw_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  tlpw_in_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output tlpw_out_t   m_data
);

    tlpw_cfg_t  cfg_reg;
    logic       cfg_we;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign cfg_we  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_we) begin
            unique case (reg_idx)
                REG_PAGING_ON:  cfg_reg.paging_on      <= pwdata[0];
                REG_PROTECT_ON: cfg_reg.protect_on     <= pwdata[0];
                REG_DIR_BASE:   cfg_reg.dir_base_frame <= pwdata[19:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_PAGING_ON:  prdata = {31'd0, cfg_reg.paging_on};
            REG_PROTECT_ON: prdata = {31'd0, cfg_reg.protect_on};
            REG_DIR_BASE:   prdata = {12'd0, cfg_reg.dir_base_frame};
            default:        prdata = 32'd0;
        endcase
    end

    tlpw_walk u_walk (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

@@ dv/two_level_page_walk_memory_top_test.sv @@
// ============================================================================
// Two-level page walk memory testbench
// Builds page directories and tables in memory with physical writes, then
// runs directed and random physical and virtual accesses under several
// paging settings. Each result is checked against a predicted result.
// ============================================================================
module two_level_page_walk_memory_top_test;
    import tlpw_pkg::*;

    localparam int MEM_SIZE    = 1 << MEM_ADDR_BITS;
    localparam int CYCLE_LIMIT = 600000;
    localparam int NUM_PHASES  = 7;

    class page_walk_scoreboard;
        bit [7:0]   mem_image [MEM_SIZE];
        bit         mem_known [MEM_SIZE];
        tlpw_cfg_t  cfg = '0;
        tlpw_out_t  access_results_due [$];
        bit         touched_unwritten;
        int         errors;

        function void set_register(logic [1:0] index, logic [31:0] value);
            case (index)
                REG_PAGING_ON: begin
                    cfg.paging_on = value[0];
                end
                REG_PROTECT_ON: begin
                    cfg.protect_on = value[0];
                end
                REG_DIR_BASE: begin
                    cfg.dir_base_frame = value[19:0];
                end
                default: begin
                end
            endcase
        endfunction

        function bit fits(logic [31:0] a, logic [2:0] n);
            return ({1'b0, a} + 33'(n)) <= MEM_BYTES;
        endfunction

        function logic [31:0] load(logic [31:0] a, logic [2:0] n);
            logic [31:0] v;
            logic [31:0] b;
            v = '0;
            for (int i = 0; i < n; i++) begin
                b = a + 32'(i);
                if (!mem_known[b[MEM_ADDR_BITS-1:0]]) touched_unwritten = 1'b1;
                v[8*i +: 8] = mem_image[b[MEM_ADDR_BITS-1:0]];
            end
            return v;
        endfunction

        function void store(logic [31:0] a, logic [2:0] n, logic [31:0] d);
            logic [31:0] b;
            for (int i = 0; i < n; i++) begin
                b = a + 32'(i);
                mem_image[b[MEM_ADDR_BITS-1:0]] = d[8*i +: 8];
                mem_known[b[MEM_ADDR_BITS-1:0]] = 1'b1;
            end
        endfunction

        // With commit low nothing is stored, so a candidate access can be
        // checked for reads of bytes that were never written.
        function tlpw_out_t page_walk_access(tlpw_in_t it, bit commit);
            tlpw_out_t   res;
            logic [31:0] addr;
            logic [31:0] dir_addr;
            logic [31:0] tab_addr;
            logic [31:0] dir_entry;
            logic [31:0] tab_entry;
            bit          is_virtual;
            bit          is_write;
            res = '0;
            touched_unwritten = 1'b0;
            addr = it.access_address;
            is_virtual = (it.func == FN_VIRT_RD) || (it.func == FN_VIRT_WR);
            is_write = (it.func == FN_PHYS_WR) || (it.func == FN_VIRT_WR);
            res.phys_address = addr;
            res.status = STAT_OK;
            if (it.access_length == 3'd0 || it.access_length > 3'd4 ||
                (is_virtual && cfg.paging_on && it.access_length == 3'd3)) begin
                res.phys_address = '0;
                res.status = STAT_BAD_LEN;
            end else if (is_virtual && cfg.paging_on && cfg.protect_on) begin
                dir_addr = {cfg.dir_base_frame, addr[31:22], 2'b00};
                if (!fits(dir_addr, 3'd4)) begin
                    res.phys_address = dir_addr;
                    res.status = STAT_RANGE;
                end else begin
                    dir_entry = load(dir_addr, 3'd4);
                    if (!dir_entry[0]) begin
                        res.phys_address = '0;
                        res.status = STAT_DIR_ABSENT;
                    end else begin
                        tab_addr = {dir_entry[31:12], addr[21:12], 2'b00};
                        if (!fits(tab_addr, 3'd4)) begin
                            res.phys_address = tab_addr;
                            res.status = STAT_RANGE;
                        end else begin
                            tab_entry = load(tab_addr, 3'd4);
                            if (!tab_entry[0]) begin
                                res.phys_address = '0;
                                res.status = STAT_TABLE_ABSENT;
                            end else begin
                                res.phys_address = {tab_entry[31:12], addr[11:0]};
                            end
                        end
                    end
                end
            end
            if (res.status == STAT_OK) begin
                if (!fits(res.phys_address, it.access_length)) begin
                    res.status = STAT_RANGE;
                end else if (is_write) begin
                    if (commit) store(res.phys_address, it.access_length, it.write_data);
                end else begin
                    res.read_data = load(res.phys_address, it.access_length);
                end
            end
            return res;
        endfunction

        function void note_input(tlpw_in_t it);
            access_results_due.push_back(page_walk_access(it, 1'b1));
        endfunction

        task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
            $display("mismatch: %s got %h expected %h", what, got, want);
            errors++;
        endtask

        task check_result(tlpw_out_t got);
            tlpw_out_t want;
            if (access_results_due.size() == 0) begin
                report_mismatch("transaction with none due, phys_address",
                                got.phys_address, '0);
            end else begin
                want = access_results_due.pop_front();
                if (got.read_data !== want.read_data)
                    report_mismatch("read_data", got.read_data, want.read_data);
                if (got.phys_address !== want.phys_address)
                    report_mismatch("phys_address", got.phys_address, want.phys_address);
                if (got.status !== want.status)
                    report_mismatch("status", 32'(got.status), 32'(want.status));
            end
        endtask
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid = 1'b0;
    logic        s_ready;
    tlpw_in_t    s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    tlpw_out_t   m_data;

    page_walk_scoreboard sb = new();
    bit steady = 1'b0;
    int cycle_count = 0;

    logic [9:0]  dir_pool [5] = '{10'd0, 10'd1, 10'd2, 10'd3, 10'd1023};
    logic [9:0]  tab_pool [6] = '{10'd0, 10'd1, 10'd2, 10'd3, 10'd1022, 10'd1023};
    int          phase_items   [NUM_PHASES] = '{160, 420, 150, 100, 100, 120, 400};
    bit          phase_paging  [NUM_PHASES] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1};
    bit          phase_protect [NUM_PHASES] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1};
    logic [19:0] phase_dir     [NUM_PHASES] = '{20'h0, 20'h1, 20'h1, 20'hFFFFF,
                                                20'hFFFFF, 20'hF, 20'h1};

    two_level_page_walk_memory_top dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("** two_level_page_walk_memory_top: FAILED **");
            $finish;
        end
    end

    always @(negedge aclk) begin
        m_ready <= steady || ($urandom_range(99) >= 17);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid === 1'b1 && m_ready) sb.check_result(m_data);
    end

    task automatic write_register(input logic [1:0] index, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {index, 2'b00};
        pwdata <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (pready !== 1'b1);
        sb.set_register(index, value);
        @(negedge aclk);
    endtask

    task automatic configure(input bit paging, input bit protect, input logic [19:0] dir);
        write_register(REG_PAGING_ON, 32'(paging));
        write_register(REG_PROTECT_ON, 32'(protect));
        write_register(REG_DIR_BASE, 32'(dir));
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic send_item(input tlpw_in_t item);
        while (!steady && $urandom_range(99) < 17) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= item;
        do @(posedge aclk); while (s_ready !== 1'b1);
        sb.note_input(item);
        @(negedge aclk);
    endtask

    task automatic send_fields(input logic [1:0] func, input logic [31:0] addr,
                               input logic [2:0] len, input logic [31:0] data);
        tlpw_in_t item;
        item.func = func;
        item.access_address = addr;
        item.access_length = len;
        item.write_data = data;
        send_item(item);
    endtask

    task automatic wait_drained();
        while (sb.access_results_due.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        @(negedge aclk);
    endtask

    function automatic logic [31:0] random_phys_address();
        int r;
        r = $urandom_range(99);
        if (r < 5) return $urandom;
        if (r < 15) return 32'hFFF0 + $urandom_range(15);
        if (r < 20) return 32'hF000 + $urandom_range(31);
        if (r < 25) return $urandom_range(32'h3FFF);
        if (r < 75) return 32'h4000 + $urandom_range(255);
        return 32'h4000 + $urandom_range(32'hBFFF);
    endfunction

    function automatic tlpw_in_t next_random_access();
        tlpw_in_t  item;
        int        r;
        logic [9:0]  dir_idx;
        logic [9:0]  tab_idx;
        logic [11:0] offset;
        repeat (40) begin
            item.func = 2'($urandom_range(3));
            item.write_data = $urandom;
            r = $urandom_range(99);
            if (r < 4) item.access_length = (r == 0) ? 3'd0 : 3'(r + 4);
            else if (r < 14) item.access_length = 3'd3;
            else if (r < 40) item.access_length = 3'd1;
            else if (r < 65) item.access_length = 3'd2;
            else item.access_length = 3'd4;
            if ((item.func == FN_VIRT_RD || item.func == FN_VIRT_WR) &&
                sb.cfg.paging_on && sb.cfg.protect_on) begin
                dir_idx = ($urandom_range(9) == 0) ? 10'($urandom) : dir_pool[$urandom_range(4)];
                tab_idx = ($urandom_range(9) == 0) ? 10'($urandom) : tab_pool[$urandom_range(5)];
                r = $urandom_range(99);
                if (r < 60) offset = 12'($urandom_range(63));
                else if (r < 80) offset = 12'hFF0 + 12'($urandom_range(15));
                else offset = 12'($urandom);
                item.access_address = {dir_idx, tab_idx, offset};
            end else begin
                item.access_address = random_phys_address();
            end
            void'(sb.page_walk_access(item, 1'b0));
            if (!sb.touched_unwritten) return item;
        end
        item.func = FN_PHYS_WR;
        item.access_length = 3'd4;
        item.access_address = 32'h4000 + $urandom_range(252);
        item.write_data = $urandom;
        return item;
    endfunction

    initial begin
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_drained();
            configure(phase_paging[p], phase_protect[p], phase_dir[p]);
            @(negedge aclk);
            steady = (p == NUM_PHASES - 1);
            if (p == 0) begin
                // Directory in frame 1, tables in frames 2 and 3.
                send_fields(FN_PHYS_WR, 32'h1000, 3'd4, 32'h0000_2001);
                send_fields(FN_PHYS_WR, 32'h1004, 3'd4, 32'h0000_3001);
                send_fields(FN_PHYS_WR, 32'h1008, 3'd4, 32'h0000_3000);
                send_fields(FN_PHYS_WR, 32'h100C, 3'd4, 32'h1234_5001);
                send_fields(FN_PHYS_WR, 32'h1FFC, 3'd4, 32'h0000_2FFF);
                send_fields(FN_PHYS_WR, 32'h2000, 3'd4, 32'h0000_4001);
                send_fields(FN_PHYS_WR, 32'h2004, 3'd4, 32'h0000_5001);
                send_fields(FN_PHYS_WR, 32'h2008, 3'd4, 32'h0000_6000);
                send_fields(FN_PHYS_WR, 32'h200C, 3'd4, 32'h8000_0001);
                send_fields(FN_PHYS_WR, 32'h2FF8, 3'd4, 32'h0000_FFFF);
                send_fields(FN_PHYS_WR, 32'h2FFC, 3'd4, 32'h0000_F001);
                send_fields(FN_PHYS_WR, 32'h3000, 3'd4, 32'h0000_6001);
                send_fields(FN_PHYS_WR, 32'h3004, 3'd4, 32'h0000_7003);
                send_fields(FN_PHYS_WR, 32'h3008, 3'd4, 32'h0000_0000);
                send_fields(FN_PHYS_WR, 32'h300C, 3'd4, 32'h0000_9001);
                send_fields(FN_PHYS_WR, 32'h3FF8, 3'd4, 32'h0000_A001);
                send_fields(FN_PHYS_WR, 32'h3FFC, 3'd4, 32'h0000_0000);
                send_fields(FN_PHYS_WR, 32'hFFFC, 3'd4, 32'hFFFF_FFFF);
                send_fields(FN_PHYS_WR, 32'hFFFD, 3'd3, 32'h5A00_A5C3);
                send_fields(FN_PHYS_RD, 32'hFFFD, 3'd3, 32'h0);
                send_fields(FN_PHYS_RD, 32'hFFFF, 3'd2, 32'h0);
                send_fields(FN_PHYS_RD, 32'hFFFF_FFFF, 3'd4, 32'h0);
                send_fields(FN_PHYS_WR, 32'h0001_0000, 3'd4, 32'h1357_9BDF);
                send_fields(FN_PHYS_RD, 32'h4000, 3'd0, 32'h0);
                send_fields(FN_VIRT_WR, 32'h4000, 3'd7, 32'hFFFF_FFFF);
                send_fields(FN_VIRT_RD, 32'hFFFD, 3'd3, 32'h0);
                send_fields(FN_VIRT_RD, 32'hFFFC, 3'd4, 32'h0);
            end else if (p == 1) begin
                send_fields(FN_VIRT_WR, 32'h0000_0000, 3'd4, 32'hDEAD_BEEF);
                send_fields(FN_VIRT_RD, 32'h0000_0000, 3'd4, 32'h0);
                send_fields(FN_VIRT_RD, 32'h0080_0000, 3'd1, 32'h0);
                send_fields(FN_VIRT_RD, 32'h0000_2000, 3'd2, 32'h0);
                send_fields(FN_VIRT_WR, 32'h00C0_0000, 3'd4, 32'h0BAD_F00D);
                send_fields(FN_VIRT_RD, 32'h0000_3010, 3'd1, 32'h0);
                send_fields(FN_VIRT_RD, 32'hFFFF_FFFE, 3'd4, 32'h0);
                send_fields(FN_VIRT_RD, 32'h0000_0000, 3'd3, 32'h0);
                send_fields(FN_VIRT_WR, 32'h0040_0123, 3'd2, 32'h1234_ABCD);
                send_fields(FN_VIRT_RD, 32'h0040_0123, 3'd2, 32'h0);
            end
            for (int n = 0; n < phase_items[p]; n++) send_item(next_random_access());
            s_valid <= 1'b0;
        end
        while (sb.access_results_due.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (sb.errors == 0 && sb.access_results_due.size() == 0) begin
            $display("** two_level_page_walk_memory_top: PASSED **");
        end else begin
            $display("** two_level_page_walk_memory_top: FAILED **");
        end
        $finish;
    end

endmodule
